/* hw/rtl/dma2d_pkg.sv */
// Shared constants and types for the 2D DMA channel sequencer.
`timescale 1ns / 1ps

package dma2d_pkg;

    // Default widths of the address and count datapaths
    localparam int unsigned ADDR_BITS_DEF  = 32;
    localparam int unsigned COUNT_BITS_DEF = 32;

    // Configuration register file
    localparam int unsigned CFG_DATA_BITS  = 32;
    localparam int unsigned CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_START_ADDRESS  = 3'd0,
        CFG_ROW_COUNT      = 3'd1,
        CFG_ROW_STRIDE     = 3'd2,
        CFG_ROW_TOTAL      = 3'd3,
        CFG_FRAME_STRIDE   = 3'd4,
        CFG_MODE           = 3'd5,
        CFG_IRQ_MODE       = 3'd6,
        CFG_ELEM_SIZE_LOG2 = 3'd7
    } t_cfg_index;

    // Item opcodes
    localparam int unsigned OPCODE_BITS = 3;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_START   = 3'd0,
        OP_STOP    = 3'd1,
        OP_ELEMENT = 3'd2,
        OP_PERIPH  = 3'd3,
        OP_CLEAR   = 3'd4
    } t_opcode;

    // Interrupt modes
    typedef enum logic [1:0] {
        IRQ_NONE     = 2'd0,
        IRQ_ROW_END  = 2'd1,
        IRQ_FRAME    = 2'd2,
        IRQ_PERIPH   = 2'd3
    } t_irq_mode;

    // Mode bits and clear-mask bits
    localparam int unsigned MODE_BIT_2D   = 0;
    localparam int unsigned MODE_BIT_AUTO = 1;
    localparam int unsigned CLR_BIT_DONE  = 0;
    localparam int unsigned CLR_BIT_ERROR = 1;

endpackage

/* hw/rtl/dma_2d_channel_sequencer.sv */
// Top level of the 2D DMA channel address and count sequencer.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command item: an
//   opcode (start, stop, element moved, peripheral event, clear status) and a
//   clear mask. Output channel (o_out_valid / i_out_stall) returns exactly one
//   result item per command: current address, X and Y counts left, running,
//   done and error flags, and an interrupt pulse for that item.
//   The configuration port (i_cfg_wr_en, i_cfg_index, i_cfg_wdata) writes one
//   setup register per cycle; the user writes it only while no item is in
//   flight (not enforced); address, count and stride ignore writes while running.
// Flow and throughput:
//   An accepted item is captured in the input register; its result enters the
//   result register once that is free or draining. One item per cycle is
//   sustained unless the receiver stalls; the rate is set by the channel state
//   update, one add, decrement and compare per cycle between the two registers.
// Reset:
//   Synchronous active-low reset clears the channel state, the setup
//   registers and both valid flags.
// Stall:
//   While the receiver stalls, the result holds; one more item is still
//   taken into the input register, after which o_in_stall rises.

module dma_2d_channel_sequencer
    import dma2d_pkg::*;
#(
    parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF,
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,

    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [OPCODE_BITS-1:0]    i_opcode,
    input  logic [1:0]                i_clear_mask,

    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [ADDR_BITS-1:0]      o_current_address,
    output logic [COUNT_BITS-1:0]     o_x_left,
    output logic [COUNT_BITS-1:0]     o_y_left,
    output logic                      o_is_running,
    output logic                      o_is_done,
    output logic                      o_is_error,
    output logic                      o_irq_pulse
);

    // Setup registers
    logic [CFG_DATA_BITS-1:0] r_start_address;
    logic [CFG_DATA_BITS-1:0] r_row_count;
    logic [CFG_DATA_BITS-1:0] r_row_stride;
    logic [CFG_DATA_BITS-1:0] r_row_total;
    logic [CFG_DATA_BITS-1:0] r_frame_stride;
    logic [1:0]               r_mode;
    t_irq_mode                r_irq_mode;
    logic [1:0]               r_elem_size_log2;

    // Channel state
    logic [ADDR_BITS-1:0]     r_addr;
    logic [COUNT_BITS-1:0]    r_x;
    logic [COUNT_BITS-1:0]    r_y;
    logic                     r_run;
    logic                     r_done;
    logic                     r_err;

    logic [ADDR_BITS-1:0]     n_addr;
    logic [COUNT_BITS-1:0]    n_x;
    logic [COUNT_BITS-1:0]    n_y;
    logic                     n_run;
    logic                     n_done;
    logic                     n_err;
    logic                     n_irq;

    // Input register
    logic                     r_in_vld;
    logic [OPCODE_BITS-1:0]   r_in_op;
    logic [1:0]               r_in_mask;

    // Result register
    logic                     r_out_vld;
    logic [ADDR_BITS-1:0]     r_out_addr;
    logic [COUNT_BITS-1:0]    r_out_x;
    logic [COUNT_BITS-1:0]    r_out_y;
    logic                     r_out_run;
    logic                     r_out_done;
    logic                     r_out_err;
    logic                     r_out_irq;

    logic                     out_free;
    logic                     fire;
    logic                     in_take;

    // Resized setup values
    logic [ADDR_BITS+CFG_DATA_BITS-1:0] start_ext;
    logic [ADDR_BITS+CFG_DATA_BITS-1:0] stride_ext;
    logic [ADDR_BITS+CFG_DATA_BITS-1:0] fstride_ext;
    logic [ADDR_BITS-1:0]     start_addr;
    logic [ADDR_BITS-1:0]     stride_addr;
    logic [ADDR_BITS-1:0]     fstride_addr;
    logic [COUNT_BITS-1:0]    row_count_c;
    logic [COUNT_BITS-1:0]    row_total_c;

    // Start checks
    logic [CFG_DATA_BITS-1:0] esize;
    logic [CFG_DATA_BITS-1:0] esize_neg;
    logic                     ld_misalign;
    logic                     ld_refuse;

    // Element step
    logic [ADDR_BITS-1:0]     step_addr;
    logic [COUNT_BITS-1:0]    step_x;

    assign start_ext    = {{ADDR_BITS{1'b0}}, r_start_address};
    assign stride_ext   = {{ADDR_BITS{r_row_stride[CFG_DATA_BITS-1]}}, r_row_stride};
    assign fstride_ext  = {{ADDR_BITS{r_frame_stride[CFG_DATA_BITS-1]}}, r_frame_stride};
    assign start_addr   = start_ext[ADDR_BITS-1:0];
    assign stride_addr  = stride_ext[ADDR_BITS-1:0];
    assign fstride_addr = fstride_ext[ADDR_BITS-1:0];
    assign row_count_c  = r_row_count[COUNT_BITS-1:0];
    assign row_total_c  = r_row_total[COUNT_BITS-1:0];

    // Check alignment and stride against the element size
    assign esize     = CFG_DATA_BITS'(1) << r_elem_size_log2;
    assign esize_neg = CFG_DATA_BITS'(0) - esize;

    always_comb begin
        case (r_elem_size_log2)
            2'd0:    ld_misalign = 1'b0;
            2'd1:    ld_misalign = r_start_address[0];
            2'd2:    ld_misalign = |r_start_address[1:0];
            default: ld_misalign = |r_start_address[2:0];
        endcase
    end

    assign ld_refuse = (r_mode[MODE_BIT_2D] && (r_row_total == '0))
                    || ((r_row_stride != esize) && (r_row_stride != esize_neg));

    assign step_addr = r_addr + stride_addr;
    assign step_x    = r_x - COUNT_BITS'(1);

    // Handshake: process when the result register is free or being drained
    assign out_free   = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_vld && !out_free;

    // Next channel state for the item in the input register
    always_comb begin
        n_addr = r_addr;
        n_x    = r_x;
        n_y    = r_y;
        n_run  = r_run;
        n_done = r_done;
        n_err  = r_err;
        n_irq  = 1'b0;
        case (t_opcode'(r_in_op))
            OP_START: begin
                if (ld_misalign || ld_refuse) begin
                    n_err = 1'b1;
                end
                if (ld_refuse) begin
                    n_run = 1'b0;
                end else begin
                    n_run  = 1'b1;
                    n_addr = start_addr;
                    n_x    = row_count_c;
                    n_y    = row_total_c;
                end
            end
            OP_STOP: begin
                n_run = 1'b0;
            end
            OP_ELEMENT: begin
                if (r_run) begin
                    n_addr = step_addr;
                    n_x    = step_x;
                    if (step_x == '0) begin
                        n_irq = (r_irq_mode == IRQ_ROW_END);
                        if (r_mode[MODE_BIT_2D] && (r_y > COUNT_BITS'(1))) begin
                            // step to the next row; the last element step is undone
                            n_y    = r_y - COUNT_BITS'(1);
                            n_x    = row_count_c;
                            n_addr = r_addr + fstride_addr;
                        end else begin
                            if (r_mode[MODE_BIT_2D] && (r_irq_mode == IRQ_FRAME)) begin
                                n_irq = 1'b1;
                            end
                            if (r_mode[MODE_BIT_AUTO]) begin
                                // reload with the same checks as a start
                                if (ld_misalign || ld_refuse) begin
                                    n_err = 1'b1;
                                end
                                if (ld_refuse) begin
                                    n_run = 1'b0;
                                end else begin
                                    n_addr = start_addr;
                                    n_x    = row_count_c;
                                    n_y    = row_total_c;
                                end
                            end else begin
                                n_run  = 1'b0;
                                n_done = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_PERIPH: begin
                n_irq = (r_irq_mode == IRQ_PERIPH);
            end
            OP_CLEAR: begin
                if (r_in_mask[CLR_BIT_DONE]) begin
                    n_done = 1'b0;
                end
                if (r_in_mask[CLR_BIT_ERROR]) begin
                    n_err = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Hold setup, state, input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_address  <= '0;
            r_row_count      <= '0;
            r_row_stride     <= '0;
            r_row_total      <= '0;
            r_frame_stride   <= '0;
            r_mode           <= '0;
            r_irq_mode       <= IRQ_NONE;
            r_elem_size_log2 <= '0;
            r_addr           <= '0;
            r_x              <= '0;
            r_y              <= '0;
            r_run            <= 1'b0;
            r_done           <= 1'b0;
            r_err            <= 1'b0;
            r_in_vld         <= 1'b0;
            r_out_vld        <= 1'b0;
        end else begin
            // Take setup writes; drop address, count and stride writes while running
            if (i_cfg_wr_en) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_START_ADDRESS:  if (!r_run) r_start_address <= i_cfg_wdata;
                    CFG_ROW_COUNT:      if (!r_run) r_row_count     <= i_cfg_wdata;
                    CFG_ROW_STRIDE:     if (!r_run) r_row_stride    <= i_cfg_wdata;
                    CFG_ROW_TOTAL:      if (!r_run) r_row_total     <= i_cfg_wdata;
                    CFG_FRAME_STRIDE:   if (!r_run) r_frame_stride  <= i_cfg_wdata;
                    CFG_MODE:           r_mode           <= i_cfg_wdata[1:0];
                    CFG_IRQ_MODE:       r_irq_mode       <= t_irq_mode'(i_cfg_wdata[1:0]);
                    CFG_ELEM_SIZE_LOG2: r_elem_size_log2 <= i_cfg_wdata[1:0];
                    default: begin
                    end
                endcase
            end

            // Advance channel state
            if (fire) begin
                r_addr <= n_addr;
                r_x    <= n_x;
                r_y    <= n_y;
                r_run  <= n_run;
                r_done <= n_done;
                r_err  <= n_err;
            end

            // Input register valid
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end

            // Result register valid
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_op   <= i_opcode;
            r_in_mask <= i_clear_mask;
        end
        if (fire) begin
            r_out_addr <= n_addr;
            r_out_x    <= n_x;
            r_out_y    <= n_y;
            r_out_run  <= n_run;
            r_out_done <= n_done;
            r_out_err  <= n_err;
            r_out_irq  <= n_irq;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_current_address = r_out_addr;
    assign o_x_left          = r_out_x;
    assign o_y_left          = r_out_y;
    assign o_is_running      = r_out_run;
    assign o_is_done         = r_out_done;
    assign o_is_error        = r_out_err;
    assign o_irq_pulse       = r_out_irq;

endmodule

/* hw/rtl/dma2d_checker.sv */
// Port-level assertions for the 2D DMA channel sequencer and their binding.
`timescale 1ns / 1ps

module dma2d_checker
    import dma2d_pkg::*;
#(
    parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF,
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [ADDR_BITS-1:0]  o_current_address,
    input logic [COUNT_BITS-1:0] o_x_left,
    input logic [COUNT_BITS-1:0] o_y_left
);

    // Reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    // The input side only stalls behind a held result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // A stalled result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_current_address)
            && $stable(o_x_left) && $stable(o_y_left))
        else $error("result payload changed while stalled");

endmodule

bind dma_2d_channel_sequencer dma2d_checker #(
    .ADDR_BITS  (ADDR_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_dma2d_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_current_address (o_current_address),
    .o_x_left          (o_x_left),
    .o_y_left          (o_y_left)
);
